### src/pcfs_pkg.sv
// Shared types, constants and step functions for the central-force particle step.
// No dependencies; used by photon_central_force_step.
package pcfs_pkg;

  localparam int ITER = 32;
  localparam logic [31:0] M32 = 32'hFFFF_FFFF;
  localparam int EXTRA_K = 1800;
  localparam logic signed [34:0] WIN_LO = -35'sd13107200;
  localparam logic signed [34:0] WIN_HI = 35'sd65536000;
  localparam logic signed [34:0] S32_MAX = 35'sd2147483647;
  localparam logic signed [34:0] S32_MIN = -35'sd2147483648;

  // Stage schedule of the pipeline
  localparam int ST_DIFF  = 0;
  localparam int ST_SQR   = 1;
  localparam int ST_SUM   = 2;
  localparam int ST_INIT  = 3;
  localparam int ST_SQA   = 4;
  localparam int ST_T1    = ST_SQA + ITER;
  localparam int ST_D2I   = ST_T1 + 1;
  localparam int ST_DVB   = ST_D2I + 1;
  localparam int ST_FORCE = ST_DVB + ITER;
  localparam int ST_ACC   = ST_FORCE + 1;
  localparam int ST_DIVA  = ST_ACC + 1;
  localparam int ST_PAC   = ST_DIVA + ITER;
  localparam int ST_VEL   = ST_PAC + 1;
  localparam int ST_ABS   = ST_VEL + 1;
  localparam int ST_CHK   = ST_ABS + 1;
  localparam int ST_SHF   = ST_CHK + 1;
  localparam int ST_CSQ   = ST_SHF + 1;
  localparam int ST_CSUM  = ST_CSQ + 1;
  localparam int ST_SQB   = ST_CSUM + 1;
  localparam int ST_CLD   = ST_SQB + ITER;
  localparam int ST_DIVB  = ST_CLD + 1;
  localparam int ST_PDT   = ST_DIVB + ITER;
  localparam int ST_POS   = ST_PDT + 1;
  localparam int N_STG    = ST_POS + 1;

  typedef enum logic [2:0] {
    CFG_HOLE_X  = 3'd0,
    CFG_HOLE_Y  = 3'd1,
    CFG_HORIZON = 3'd2,
    CFG_ATTRACT = 3'd3,
    CFG_SPEED   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    FATE_MOVE = 2'd0,
    FATE_CAPT = 2'd1,
    FATE_LEFT = 2'd2,
    FATE_IDLE = 2'd3
  } fate_e;

  typedef struct packed {
    logic signed [31:0] hole_x;
    logic signed [31:0] hole_y;
    logic [30:0]        horizon;
    logic [31:0]        attract;
    logic [30:0]        lim;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               act;
    logic [16:0]        dt;
    fate_e              fate;
    logic [31:0]        ux;
    logic [31:0]        uy;
    logic               nx;
    logic               ny;
    logic [63:0]        sqx;
    logic [63:0]        sqy;
    logic [61:0]        sq_lim;
    logic [63:0]        d2;
    logic               far;
    logic               cap;
    logic               zacc;
    logic [63:0]        sn;
    logic [63:0]        sr;
    logic [63:0]        drem;
    logic [31:0]        dq;
    logic               dsat;
    logic [31:0]        t1;
    logic [31:0]        d;
    logic [31:0]        f;
    logic [31:0]        remx;
    logic [31:0]        remy;
    logic [31:0]        qx;
    logic [31:0]        qy;
    logic [31:0]        dv;
    logic [48:0]        pdx;
    logic [48:0]        pdy;
    logic signed [34:0] vxn;
    logic signed [34:0] vyn;
    logic [33:0]        ax2;
    logic [33:0]        ay2;
    logic               big;
    logic               over;
    logic [30:0]        cx;
    logic [30:0]        cy;
  } item_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
  } div_t;

  // One digit of the bitwise integer square root
  function automatic sq_t sqrt_step(input logic [63:0] n, input logic [63:0] r,
                                    input logic [63:0] b);
    sq_t o;
    logic [64:0] rb;
    rb = {1'b0, r} + {1'b0, b};
    if ({1'b0, n} >= rb) begin
      o.n = n - rb[63:0];
      o.r = (r >> 1) + b;
    end else begin
      o.n = n;
      o.r = r >> 1;
    end
    return o;
  endfunction

  // One quotient bit of restoring division; q holds the dividend low bits
  function automatic div_t udiv_step(input logic [31:0] rem, input logic [31:0] q,
                                     input logic [31:0] dv);
    div_t o;
    logic [32:0] t;
    logic [32:0] s;
    logic ge;
    t = {rem, q[31]};
    s = t - {1'b0, dv};
    ge = (t >= {1'b0, dv});
    o.rem = ge ? s[31:0] : t[31:0];
    o.q = {q[30:0], ge};
    return o;
  endfunction

endpackage

### src/photon_central_force_step.sv
// Central-force particle step: a fully pipelined fixed-point Euler update.
// Depends on pcfs_pkg for the stage schedule, types and step functions.
// Output: done_o is high when the accepted item reaches pipe_q[N_STG], the last stage register.
// Throughput: one particle per cycle; busy_o is never asserted and the
// receiver cannot stall, so the pipeline always advances.
// Depth is set by the five 32-step root and divide chains, one bit per stage.
// Reset clears the valid bits and loads the default attractor settings.
module photon_central_force_step
  import pcfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic               active_in_i,
  input  logic [16:0]        time_step_i,
  output logic               done_o,
  output logic signed [31:0] pos_x_out_o,
  output logic signed [31:0] pos_y_out_o,
  output logic signed [31:0] vel_x_out_o,
  output logic signed [31:0] vel_y_out_o,
  output logic               active_out_o,
  output logic [1:0]         fate_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_data_i
);

  cfg_t cfg_q;
  item_t pipe_q [0:N_STG];
  item_t pipe_d [1:N_STG];
  item_t in_d;
  logic [N_STG:0] vld_q;

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  function automatic item_t stage_step(input item_t a, input cfg_t c, input int k);
    item_t o;
    logic [32:0] dxs, dys;
    logic [64:0] s65;
    logic [63:0] b, sh, nx64, ny64;
    logic [32:0] s33;
    logic [33:0] orv;
    logic [31:0] t1v, mgx, mgy;
    logic signed [34:0] pxn, pyn;
    logic lft;
    sq_t sq;
    div_t dvx, dvy;
    o = a;
    dxs = '0; dys = '0; s65 = '0; b = '0; sh = '0; nx64 = '0; ny64 = '0;
    s33 = '0; orv = '0; t1v = '0; mgx = '0; mgy = '0; pxn = '0; pyn = '0;
    lft = 1'b0; sq = '0; dvx = '0; dvy = '0;
    if (k == ST_DIFF) begin
      dxs = {c.hole_x[31], c.hole_x} - {a.px[31], a.px};
      dys = {c.hole_y[31], c.hole_y} - {a.py[31], a.py};
      o.nx = dxs[32];
      o.ny = dys[32];
      o.ux = dxs[32] ? 32'(33'd0 - dxs) : dxs[31:0];
      o.uy = dys[32] ? 32'(33'd0 - dys) : dys[31:0];
    end else if (k == ST_SQR) begin
      o.sqx = a.ux * a.ux;
      o.sqy = a.uy * a.uy;
      o.sq_lim = 62'(c.horizon) * 62'(c.horizon);
    end else if (k == ST_SUM) begin
      s65 = {1'b0, a.sqx} + {1'b0, a.sqy};
      o.far = s65[64];
      o.d2 = s65[64] ? 64'd0 : s65[63:0];
    end else if (k == ST_INIT) begin
      o.cap = !a.far && (a.d2 < {2'b0, a.sq_lim});
      o.zacc = a.far || (a.d2 == 64'd0);
      o.sn = a.d2;
      o.sr = '0;
      o.drem = {32'd0, c.attract};
      o.dsat = ({32'd0, c.attract} >= a.d2);
      o.dq = '0;
    end else if ((k >= ST_SQA && k < ST_SQA + ITER) || (k >= ST_DVB && k < ST_DVB + ITER)) begin
      if (k < ST_SQA + ITER) begin
        b = 64'd1 << (62 - 2 * (k - ST_SQA));
        sq = sqrt_step(a.sn, a.sr, b);
        o.sn = sq.n;
        o.sr = sq.r;
      end
      // shift-subtract divide of the left-aligned numerator by d2
      sh = {a.drem[62:0], 1'b0};
      if (a.drem[63] || sh >= a.d2) begin
        o.drem = sh - a.d2;
        o.dq = {a.dq[30:0], 1'b1};
      end else begin
        o.drem = sh;
        o.dq = {a.dq[30:0], 1'b0};
      end
    end else if (k == ST_T1) begin
      o.d = a.sr[31:0];
      t1v = a.dsat ? M32 : a.dq;
      o.t1 = t1v;
      o.drem = {21'd0, 43'(t1v) * 43'(EXTRA_K)};
    end else if (k == ST_D2I) begin
      o.dsat = (a.drem >= a.d2);
      o.dq = '0;
    end else if (k == ST_FORCE) begin
      s33 = {1'b0, a.t1} + {1'b0, (a.dsat ? M32 : a.dq)};
      o.f = (a.t1 == M32 || s33[32]) ? M32 : s33[31:0];
    end else if (k == ST_ACC) begin
      nx64 = a.zacc ? 64'd0 : a.f * a.ux;
      ny64 = a.zacc ? 64'd0 : a.f * a.uy;
      o.dv = a.zacc ? 32'd1 : a.d;
      o.remx = nx64[63:32];
      o.qx = nx64[31:0];
      o.remy = ny64[63:32];
      o.qy = ny64[31:0];
    end else if ((k >= ST_DIVA && k < ST_DIVA + ITER) ||
                 (k >= ST_DIVB && k < ST_DIVB + ITER)) begin
      dvx = udiv_step(a.remx, a.qx, a.dv);
      dvy = udiv_step(a.remy, a.qy, a.dv);
      o.remx = dvx.rem;
      o.qx = dvx.q;
      o.remy = dvy.rem;
      o.qy = dvy.q;
    end else if (k == ST_PAC) begin
      o.pdx = 49'(a.qx) * 49'(a.dt);
      o.pdy = 49'(a.qy) * 49'(a.dt);
    end else if (k == ST_VEL) begin
      o.vxn = {{3{a.vx[31]}}, a.vx} +
              (a.nx ? (35'd0 - {2'b0, a.pdx[48:16]}) : {2'b0, a.pdx[48:16]});
      o.vyn = {{3{a.vy[31]}}, a.vy} +
              (a.ny ? (35'd0 - {2'b0, a.pdy[48:16]}) : {2'b0, a.pdy[48:16]});
    end else if (k == ST_ABS) begin
      o.ax2 = a.vxn[34] ? 34'(35'd0 - a.vxn) : a.vxn[33:0];
      o.ay2 = a.vyn[34] ? 34'(35'd0 - a.vyn) : a.vyn[33:0];
    end else if (k == ST_CHK) begin
      o.big = (a.ax2 > {3'b0, c.lim}) || (a.ay2 > {3'b0, c.lim});
      o.sqx = {2'b0, 62'(a.ax2[30:0]) * 62'(a.ax2[30:0])};
      o.sqy = {2'b0, 62'(a.ay2[30:0]) * 62'(a.ay2[30:0])};
      o.sq_lim = 62'(c.lim) * 62'(c.lim);
    end else if (k == ST_SHF) begin
      o.over = a.big || ((a.sqx + a.sqy) > {2'b0, a.sq_lim});
      orv = a.ax2 | a.ay2;
      // drop low bits until both components fit in 31 bits
      if (orv[33]) begin
        o.cx = a.ax2[33:3];
        o.cy = a.ay2[33:3];
      end else if (orv[32]) begin
        o.cx = a.ax2[32:2];
        o.cy = a.ay2[32:2];
      end else if (orv[31]) begin
        o.cx = a.ax2[31:1];
        o.cy = a.ay2[31:1];
      end else begin
        o.cx = a.ax2[30:0];
        o.cy = a.ay2[30:0];
      end
    end else if (k == ST_CSQ) begin
      o.sqx = {2'b0, 62'(a.cx) * 62'(a.cx)};
      o.sqy = {2'b0, 62'(a.cy) * 62'(a.cy)};
    end else if (k == ST_CSUM) begin
      o.sn = a.sqx + a.sqy;
      o.sr = '0;
    end else if (k >= ST_SQB && k < ST_SQB + ITER) begin
      b = 64'd1 << (62 - 2 * (k - ST_SQB));
      sq = sqrt_step(a.sn, a.sr, b);
      o.sn = sq.n;
      o.sr = sq.r;
    end else if (k == ST_CLD) begin
      nx64 = {2'b0, 62'(a.cx) * 62'(c.lim)};
      ny64 = {2'b0, 62'(a.cy) * 62'(c.lim)};
      o.dv = (a.sr == 64'd0) ? 32'd1 : a.sr[31:0];
      o.remx = nx64[63:32];
      o.qx = nx64[31:0];
      o.remy = ny64[63:32];
      o.qy = ny64[31:0];
    end else if (k == ST_PDT) begin
      mgx = a.over ? a.qx : a.ax2[31:0];
      mgy = a.over ? a.qy : a.ay2[31:0];
      o.pdx = 49'(mgx) * 49'(a.dt);
      o.pdy = 49'(mgy) * 49'(a.dt);
      // hold the final velocity in the spare remainder fields
      o.remx = a.vxn[34] ? (32'd0 - mgx) : mgx;
      o.remy = a.vyn[34] ? (32'd0 - mgy) : mgy;
    end else if (k == ST_POS) begin
      if (!a.act) begin
        o.fate = FATE_IDLE;
      end else if (a.cap) begin
        o.act = 1'b0;
        o.fate = FATE_CAPT;
      end else begin
        pxn = {{3{a.px[31]}}, a.px} +
              (a.vxn[34] ? (35'd0 - {2'b0, a.pdx[48:16]}) : {2'b0, a.pdx[48:16]});
        pyn = {{3{a.py[31]}}, a.py} +
              (a.vyn[34] ? (35'd0 - {2'b0, a.pdy[48:16]}) : {2'b0, a.pdy[48:16]});
        lft = (pxn < WIN_LO) || (pxn > WIN_HI) || (pyn < WIN_LO) || (pyn > WIN_HI);
        o.act = !lft;
        o.fate = lft ? FATE_LEFT : FATE_MOVE;
        o.vx = a.remx;
        o.vy = a.remy;
        if (pxn > S32_MAX) o.px = 32'sh7FFF_FFFF;
        else if (pxn < S32_MIN) o.px = 32'sh8000_0000;
        else o.px = pxn[31:0];
        if (pyn > S32_MAX) o.py = 32'sh7FFF_FFFF;
        else if (pyn < S32_MIN) o.py = 32'sh8000_0000;
        else o.py = pyn[31:0];
      end
    end
    return o;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hole_x <= 32'sd26214400;
      cfg_q.hole_y <= 32'sd26214400;
      cfg_q.horizon <= 31'd1310720;
      cfg_q.attract <= 32'd65536;
      cfg_q.lim <= 31'd6553600;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_HOLE_X:  cfg_q.hole_x <= cfg_data_i;
        CFG_HOLE_Y:  cfg_q.hole_y <= cfg_data_i;
        CFG_HORIZON: cfg_q.horizon <= cfg_data_i[30:0];
        CFG_ATTRACT: cfg_q.attract <= cfg_data_i;
        CFG_SPEED:   cfg_q.lim <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < N_STG; k++) begin
      pipe_d[k+1] = stage_step(pipe_q[k], cfg_q, k);
    end
  end

  always_comb begin
    in_d = '0;
    in_d.px = pos_x_i;
    in_d.py = pos_y_i;
    in_d.vx = vel_x_i;
    in_d.vy = vel_y_i;
    in_d.act = active_in_i;
    in_d.dt = time_step_i;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[N_STG-1:0], start_i & ~busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    pipe_q[0] <= in_d;
    for (int k = 1; k <= N_STG; k++) begin
      pipe_q[k] <= pipe_d[k];
    end
  end

  assign done_o = vld_q[N_STG];
  assign pos_x_out_o = pipe_q[N_STG].px;
  assign pos_y_out_o = pipe_q[N_STG].py;
  assign vel_x_out_o = pipe_q[N_STG].vx;
  assign vel_y_out_o = pipe_q[N_STG].vy;
  assign active_out_o = pipe_q[N_STG].act;
  assign fate_o = pipe_q[N_STG].fate;

endmodule
